[rtl/core/sbo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbo_pkg: shared types and constants of the swing break order signal
// Quantity width, order side codes, level compare direction and the control
// bundle that drives one swing level stack.
// ----------------------------------------------------------------------------
package sbo_pkg;

  localparam int unsigned QtyBits = 16;
  localparam logic [QtyBits-1:0] OrderSizeReset = 16'd10;

  localparam logic SideBuy  = 1'b0;
  localparam logic SideSell = 1'b1;

  // A stored level is passed when the probe lies above it (swing highs)
  // or below it (swing lows).
  typedef enum logic {
    CMP_ABOVE,
    CMP_BELOW
  } sbo_cmp_e;

  typedef struct packed {
    logic en;    // a candle is transferred this cycle
    logic push;  // the candle completes a swing: push the middle level
  } sbo_stk_ctrl_t;

endpackage

[rtl/core/sbo_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbo_if: channel interfaces of the swing break order signal
// Candle input, order output and order size configuration, each a
// valid/ready channel with source and sink views.
// ----------------------------------------------------------------------------
interface sbo_candle_if #(
  parameter int unsigned PRICE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] open_price;
  logic [PRICE_BITS-1:0] high_price;
  logic [PRICE_BITS-1:0] low_price;
  logic [PRICE_BITS-1:0] close_price;

  modport source (
    output valid, open_price, high_price, low_price, close_price,
    input  ready
  );
  modport sink (
    input  valid, open_price, high_price, low_price, close_price,
    output ready
  );
endinterface

interface sbo_order_if #(
  parameter int unsigned PRICE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  side;
  logic [PRICE_BITS-1:0] entry_level;
  logic [PRICE_BITS-1:0] stop_level;
  logic [PRICE_BITS-1:0] target_level;
  logic [15:0]           quantity;
  logic                  last_order;

  modport source (
    output valid, side, entry_level, stop_level, target_level, quantity,
           last_order,
    input  ready
  );
  modport sink (
    input  valid, side, entry_level, stop_level, target_level, quantity,
           last_order,
    output ready
  );
endinterface

interface sbo_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] order_size;

  modport source (
    output valid, order_size,
    input  ready
  );
  modport sink (
    input  valid, order_size,
    output ready
  );
endinterface

[rtl/core/swing_break_order_signal.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swing_break_order_signal: swing break order generator
// Watches a candle stream for swing highs and lows and emits a buy or sell
// order when a candle breaks the most recent swing level.
// ----------------------------------------------------------------------------
// Usage:
//   candle_i carries one candle (open, high, low, close) per transfer.
//   order_o carries zero, one or two orders per candle; a buy order comes
//   before a sell order and last_order marks the final order of a candle.
//   cfg_i writes the order size; write it only while no order is pending.
// Timing:
//   A candle is fully evaluated in the cycle of its transfer; its orders are
//   presented from the next cycle on. A candle with at most one order lets
//   the next candle follow right behind it, so candles stream back to back
//   while order_o keeps up. A candle with two orders holds the input until
//   the two-entry order buffer has drained its buy order through the single
//   output port. Swing stacks pop all levels passed from the top down at once.
// Reset and stall:
//   Reset empties both stacks, clears the candle history and sets the order
//   size to 10. While order_o stalls, pending orders hold and candle_i
//   deasserts ready once the buffer cannot take a new candle's orders.
// ----------------------------------------------------------------------------
module swing_break_order_signal
  import sbo_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned PRICE_BITS  = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbo_candle_if.sink candle_i,
  sbo_cfg_if.sink    cfg_i,
  sbo_order_if.source order_o
);

  typedef logic [PRICE_BITS-1:0] price_t;

  function automatic price_t clamp_target(price_t a, price_t b);
    // 2*a - b, saturated to the price range
    logic [PRICE_BITS+1:0] t;
    t = {1'b0, a, 1'b0} - {2'b00, b};
    if (t[PRICE_BITS+1]) begin
      clamp_target = '0;
    end else if (t[PRICE_BITS]) begin
      clamp_target = '1;
    end else begin
      clamp_target = t[PRICE_BITS-1:0];
    end
  endfunction

  logic [QtyBits-1:0] order_size_q;

  price_t     mid_high_q, mid_low_q, old_high_q, old_low_q;
  logic [1:0] seen_q;
  price_t     up_high_q, up_low_q, dn_high_q, dn_low_q;
  price_t     up_high_d, up_low_d, dn_high_d, dn_low_d;

  price_t op, hi, lo, cl;
  logic   fire, swing_low, swing_high, buy_brk, sell_brk;

  sbo_stk_ctrl_t hi_ctrl, lo_ctrl;

  logic               buy_v_q, sell_v_q, buy_last_q;
  price_t             buy_entry_q, buy_stop_q, buy_target_q;
  price_t             sell_entry_q, sell_stop_q, sell_target_q;
  logic [QtyBits-1:0] qty_q;
  logic               out_fire;

  assign op = candle_i.open_price;
  assign hi = candle_i.high_price;
  assign lo = candle_i.low_price;
  assign cl = candle_i.close_price;

  // Take a new candle once the buffer will be empty after this cycle.
  assign candle_i.ready = !(buy_v_q || sell_v_q) || (order_o.ready && (buy_v_q ^ sell_v_q));
  assign fire           = candle_i.valid && candle_i.ready;
  assign out_fire       = order_o.valid && order_o.ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_size_q <= OrderSizeReset;
    end else if (cfg_i.valid) begin
      order_size_q <= cfg_i.order_size;
    end
  end

  // Middle candle vs. its neighbors once three candles are known.
  assign swing_low  = (seen_q >= 2'd2) && (mid_low_q < old_low_q) && (mid_low_q < lo)
                      && (mid_high_q < old_high_q) && (mid_high_q < hi);
  assign swing_high = (seen_q >= 2'd2) && (mid_high_q > old_high_q) && (mid_high_q > hi)
                      && (mid_low_q > old_low_q) && (mid_low_q > lo);

  assign hi_ctrl = '{en: fire, push: fire && swing_high};
  assign lo_ctrl = '{en: fire, push: fire && swing_low};

  sbo_stack #(
    .Depth (STACK_DEPTH),
    .Width (PRICE_BITS),
    .Dir   (CMP_ABOVE)
  ) u_high_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (hi_ctrl),
    .new_level_i (mid_high_q),
    .probe_i     (hi),
    .brk_o       (buy_brk)
  );

  sbo_stack #(
    .Depth (STACK_DEPTH),
    .Width (PRICE_BITS),
    .Dir   (CMP_BELOW)
  ) u_low_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (lo_ctrl),
    .new_level_i (mid_low_q),
    .probe_i     (lo),
    .brk_o       (sell_brk)
  );

  // Kept up-close and down-close candles; the first candle seeds both.
  always_comb begin
    up_high_d = up_high_q;
    up_low_d  = up_low_q;
    dn_high_d = dn_high_q;
    dn_low_d  = dn_low_q;
    if (seen_q == 2'd0 || cl > op) begin
      up_high_d = hi;
      up_low_d  = lo;
    end
    if (seen_q == 2'd0 || cl < op) begin
      dn_high_d = hi;
      dn_low_d  = lo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_high_q <= '0;
      mid_low_q  <= '0;
      old_high_q <= '0;
      old_low_q  <= '0;
      seen_q     <= 2'd0;
      up_high_q  <= '0;
      up_low_q   <= '0;
      dn_high_q  <= '0;
      dn_low_q   <= '0;
    end else if (fire) begin
      old_high_q <= mid_high_q;
      old_low_q  <= mid_low_q;
      mid_high_q <= hi;
      mid_low_q  <= lo;
      if (seen_q != 2'd3) begin
        seen_q <= seen_q + 2'd1;
      end
      up_high_q <= up_high_d;
      up_low_q  <= up_low_d;
      dn_high_q <= dn_high_d;
      dn_low_q  <= dn_low_d;
    end
  end

  // Two-entry order buffer: buy slot drains before the sell slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buy_v_q  <= 1'b0;
      sell_v_q <= 1'b0;
    end else if (fire) begin
      buy_v_q  <= buy_brk;
      sell_v_q <= sell_brk;
    end else if (out_fire) begin
      if (buy_v_q) begin
        buy_v_q <= 1'b0;
      end else begin
        sell_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      buy_entry_q   <= dn_high_d;
      buy_stop_q    <= dn_low_d;
      buy_target_q  <= clamp_target(dn_high_d, dn_low_d);
      buy_last_q    <= !sell_brk;
      sell_entry_q  <= up_low_d;
      sell_stop_q   <= up_high_d;
      sell_target_q <= clamp_target(up_low_d, up_high_d);
      qty_q         <= order_size_q;
    end
  end

  assign order_o.valid        = buy_v_q || sell_v_q;
  assign order_o.side         = buy_v_q ? SideBuy : SideSell;
  assign order_o.entry_level  = buy_v_q ? buy_entry_q : sell_entry_q;
  assign order_o.stop_level   = buy_v_q ? buy_stop_q : sell_stop_q;
  assign order_o.target_level = buy_v_q ? buy_target_q : sell_target_q;
  assign order_o.quantity     = qty_q;
  assign order_o.last_order   = buy_v_q ? buy_last_q : 1'b1;

`ifndef SYNTHESIS
  a_two_pending_no_input: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (buy_v_q && sell_v_q) |-> !candle_i.ready
  ) else $error("candle accepted while two orders pending");

  a_buy_not_last_with_sell: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (buy_v_q && sell_v_q) |-> !buy_last_q
  ) else $error("buy order marked last while a sell order follows");

  a_sell_is_last: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (order_o.valid && order_o.side == SideSell) |-> order_o.last_order
  ) else $error("sell order not marked last");
`endif

endmodule

[rtl/core/sbo_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbo_cell: one entry of a swing level stack
// Holds a level and its live flag. Takes the upper neighbor's level when the
// full stack shifts, or the new level when it is the first free slot, and
// reports whether the probe price passes the level it ends up holding.
// ----------------------------------------------------------------------------
module sbo_cell
  import sbo_pkg::*;
#(
  parameter int unsigned Width = 32,
  parameter sbo_cmp_e    Dir   = CMP_ABOVE
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sbo_stk_ctrl_t    ctrl_i,
  input  logic             full_i,
  input  logic             below_live_i,
  input  logic [Width-1:0] up_level_i,
  input  logic [Width-1:0] new_level_i,
  input  logic [Width-1:0] probe_i,
  input  logic             pop_i,
  output logic [Width-1:0] level_o,
  output logic             held_o,
  output logic             live_o,
  output logic             passed_o
);

  logic [Width-1:0] level_q, level_d;
  logic             live_q, live_p, live_d;
  logic             hit;

  always_comb begin
    level_d = level_q;
    if (ctrl_i.push && full_i) begin
      level_d = up_level_i;
    end else if (ctrl_i.push && !live_q && below_live_i) begin
      level_d = new_level_i;
    end
  end

  assign live_p = live_q | (ctrl_i.push & below_live_i);
  assign hit    = (Dir == CMP_ABOVE) ? (probe_i > level_d) : (probe_i < level_d);
  assign live_d = live_p & ~pop_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else if (ctrl_i.en) begin
      live_q <= live_d;
    end
  end

  assign level_o  = level_q;
  assign held_o   = live_q;
  assign live_o   = live_p;
  assign passed_o = live_p & hit;

endmodule

[rtl/core/sbo_stack.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbo_stack: row of level cells forming one bounded swing stack
// Cell 0 holds the oldest level; live flags form a fill gauge. A push into a
// full row shifts every level down one cell. All levels passed from the top
// down are popped in the same cycle.
// ----------------------------------------------------------------------------
module sbo_stack
  import sbo_pkg::*;
#(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 32,
  parameter sbo_cmp_e    Dir   = CMP_ABOVE
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sbo_stk_ctrl_t    ctrl_i,
  input  logic [Width-1:0] new_level_i,
  input  logic [Width-1:0] probe_i,
  output logic             brk_o
);

  logic [Width-1:0] level [Depth];
  logic [Depth-1:0] held, live, passed, pass_or_free, pop;
  logic             full;

  assign full         = held[Depth-1];
  assign pass_or_free = passed | ~live;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic             below_live;
    logic [Width-1:0] up_level;

    if (i == 0) begin : g_bottom
      assign below_live = 1'b1;
    end else begin : g_inner
      assign below_live = held[i-1];
    end

    if (i == Depth - 1) begin : g_top
      assign up_level = new_level_i;
    end else begin : g_mid
      assign up_level = level[i+1];
    end

    // Pop a cell only if every live cell above it is passed too.
    assign pop[i] = passed[i] & (&pass_or_free[Depth-1:i]);

    sbo_cell #(
      .Width (Width),
      .Dir   (Dir)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .full_i       (full),
      .below_live_i (below_live),
      .up_level_i   (up_level),
      .new_level_i  (new_level_i),
      .probe_i      (probe_i),
      .pop_i        (pop[i]),
      .level_o      (level[i]),
      .held_o       (held[i]),
      .live_o       (live[i]),
      .passed_o     (passed[i])
    );
  end

  assign brk_o = |pop;

endmodule
